// ===== hw/rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, constants and helpers for the palette tolerance match block.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned RAMP_W  = 8;
  localparam int unsigned TOL_W   = 8;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] rgb;
    logic [RAMP_W-1:0]  base;
    logic [RAMP_W-1:0]  length;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_we;      // write one table slot
    logic scan_start;   // latch query, read slot zero
    logic scan_issue;   // read next slot
    logic fin_hit;      // result from compared entry
    logic fin_miss;     // result from slot zero, found clear
    logic fin_empty;    // all-zero result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic size_zero;
    logic cmp_vld;
    logic cmp_hit;
    logic cmp_last;
    logic issue_done;
  } status_t;

  function automatic logic within_tol(input logic [COLOR_W-1:0] q,
                                      input logic [COLOR_W-1:0] e,
                                      input logic [TOL_W-1:0]   tol);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    logic       ok;
    ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      a = q[c*8 +: 8];
      b = e[c*8 +: 8];
      d = (a > b) ? (a - b) : (b - a);
      if (d > tol) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== hw/rtl/ptm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer for loads and the slot scan of a lookup.
// ----------------------------------------------------------------------------
module ptm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              cmd_i,
  input  ptm_pkg::status_t  sts_i,
  output ptm_pkg::ctrl_t    ctrl_o,
  output logic              busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == ptm_pkg::CMD_LOAD) begin
            ctrl_o.load_we = 1'b1;
          end else if (sts_i.size_zero) begin
            ctrl_o.fin_empty = 1'b1;
          end else begin
            ctrl_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // first hit wins; reads run one slot ahead of the compare
        if (sts_i.cmp_vld && sts_i.cmp_hit) begin
          ctrl_o.fin_hit = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.cmp_vld && sts_i.cmp_last) begin
          ctrl_o.fin_miss = 1'b1;
          state_d = ST_IDLE;
        end else if (!sts_i.issue_done) begin
          ctrl_o.scan_issue = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/ptm_datapath.sv =====
// ----------------------------------------------------------------------------
// ptm_datapath
// Palette table, configuration registers, compare unit and result register.
// ----------------------------------------------------------------------------
module ptm_datapath #(
  parameter int unsigned TABLE_DEPTH = ptm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptm_pkg::ctrl_t                  ctrl_i,
  output ptm_pkg::status_t                sts_o,
  input  logic [ptm_pkg::SLOT_W-1:0]      slot_i,
  input  logic [ptm_pkg::COLOR_W-1:0]     color_i,
  input  logic [ptm_pkg::RAMP_W-1:0]      ramp_base_i,
  input  logic [ptm_pkg::RAMP_W-1:0]      ramp_length_i,
  input  logic                            cfg_we_i,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptm_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            valid_o,
  output logic                            found_o,
  output logic [ptm_pkg::RAMP_W-1:0]      out_base_o,
  output logic [ptm_pkg::RAMP_W-1:0]      out_length_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [ptm_pkg::TOL_W-1:0]   tol_q;
  logic [ptm_pkg::SIZE_W-1:0]  size_q;

  ptm_pkg::entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      vld_q;
  logic [ptm_pkg::RAMP_W-1:0]  base0_q;
  logic [ptm_pkg::RAMP_W-1:0]  len0_q;

  logic [ptm_pkg::COLOR_W-1:0] qcolor_q;
  logic [AW-1:0]               last_q;
  logic [AW-1:0]               addr_q;
  logic                        issued_all_q;
  logic                        cmp_vld_q;
  logic                        cmp_last_q;
  ptm_pkg::entry_t             rd_q;
  logic                        rd_vld_q;

  logic                        valid_q;
  logic                        found_q;
  logic [ptm_pkg::RAMP_W-1:0]  base_q;
  logic [ptm_pkg::RAMP_W-1:0]  len_q;

  logic                        slot_ok;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  ptm_pkg::entry_t             wr_word;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               last_d;
  logic [AW-1:0]               last_sel;
  logic                        at_last;
  ptm_pkg::entry_t             ent;
  logic                        hit;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= '0;
      size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptm_pkg::CFG_TOLERANCE:  tol_q  <= cfg_data_i;
        ptm_pkg::CFG_TABLE_SIZE: size_q <= cfg_data_i[ptm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // loads to slots past the table depth are dropped
  assign slot_ok = (32'(slot_i) < 32'(TABLE_DEPTH));
  assign wr_en   = ctrl_i.load_we && slot_ok;
  assign wr_addr = AW'(slot_i);
  assign wr_word = '{rgb: color_i, base: ramp_base_i, length: ramp_length_i};

  // table_size saturates at the depth
  assign last_d   = (32'(size_q) > 32'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                     : AW'(size_q - 7'd1);
  assign last_sel = ctrl_i.scan_start ? last_d : last_q;
  assign rd_en    = ctrl_i.scan_start || ctrl_i.scan_issue;
  assign rd_addr  = ctrl_i.scan_start ? '0 : addr_q;
  assign at_last  = (rd_addr == last_sel);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      base0_q  <= '0;
      len0_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
        if (wr_addr == '0) begin
          base0_q <= ramp_base_i;
          len0_q  <= ramp_length_i;
        end
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_start) begin
      qcolor_q <= color_i;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        addr_q       <= rd_addr + 1'b1;
        issued_all_q <= at_last;
        cmp_last_q   <= at_last;
      end
    end
  end

  // a never-written slot reads as zero
  assign ent = rd_vld_q ? rd_q : '0;
  assign hit = ptm_pkg::within_tol(qcolor_q, ent.rgb, tol_q);

  assign sts_o.size_zero  = (size_q == '0);
  assign sts_o.cmp_vld    = cmp_vld_q;
  assign sts_o.cmp_hit    = hit;
  assign sts_o.cmp_last   = cmp_last_q;
  assign sts_o.issue_done = issued_all_q;

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.fin_hit || ctrl_i.fin_miss || ctrl_i.fin_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin_hit) begin
      found_q <= 1'b1;
      base_q  <= ent.base;
      len_q   <= ent.length;
    end else if (ctrl_i.fin_miss) begin
      found_q <= 1'b0;
      base_q  <= base0_q;
      len_q   <= len0_q;
    end else if (ctrl_i.fin_empty) begin
      found_q <= 1'b0;
      base_q  <= '0;
      len_q   <= '0;
    end
  end

  assign valid_o      = valid_q;
  assign found_o      = found_q;
  assign out_base_o   = base_q;
  assign out_length_o = len_q;

endmodule

// ===== hw/rtl/palette_tolerance_match.sv =====
// ----------------------------------------------------------------------------
// palette_tolerance_match
// Palette lookup: first table entry within a per-component RGB tolerance.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load (cmd 0) writes
// one slot in that cycle and gives no result. A lookup (cmd 1) scans slots
// from zero through one shared compare unit, registered table reads running
// one slot ahead of the compare; its result shows on valid_o for one cycle
// and must be taken then. A lookup ends at the first hit or after the last
// slot (table_size, saturated at TABLE_DEPTH); an empty table needs no scan.
// busy stays high for the scan. The table clears at reset with no sweep.
// Configuration writes apply at once and belong to idle periods only.
module palette_tolerance_match #(
  parameter int unsigned TABLE_DEPTH = ptm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [ptm_pkg::SLOT_W-1:0]      slot_i,
  input  logic [ptm_pkg::COLOR_W-1:0]     color_i,
  input  logic [ptm_pkg::RAMP_W-1:0]      ramp_base_i,
  input  logic [ptm_pkg::RAMP_W-1:0]      ramp_length_i,
  input  logic                            cfg_we_i,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptm_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            valid_o,
  output logic                            found_o,
  output logic [ptm_pkg::RAMP_W-1:0]      out_base_o,
  output logic [ptm_pkg::RAMP_W-1:0]      out_length_o
);

  ptm_pkg::ctrl_t   ctrl;
  ptm_pkg::status_t sts;

  ptm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (sts),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  ptm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sts_o         (sts),
    .slot_i        (slot_i),
    .color_i       (color_i),
    .ramp_base_i   (ramp_base_i),
    .ramp_length_i (ramp_length_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .found_o       (found_o),
    .out_base_o    (out_base_o),
    .out_length_o  (out_length_o)
  );

endmodule

// ===== hw/rtl/ptm_checker.sv =====
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks on the palette tolerance match block.
// ----------------------------------------------------------------------------
module ptm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cmd_i,
  input logic valid_o
);

  // a load never produces a result word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == ptm_pkg::CMD_LOAD) |=> !valid_o)
    else $error("result after a load");

  // a lookup either answers at once or starts a scan
  a_lookup_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == ptm_pkg::CMD_LOOKUP) |=> (busy || valid_o))
    else $error("lookup dropped");

  // end of a scan always delivers a word
  a_scan_ends_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("scan ended without result");

  // results appear only once the scan is over
  a_word_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result while busy");

endmodule

bind palette_tolerance_match ptm_checker u_ptm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .cmd_i   (cmd_i),
  .valid_o (valid_o)
);
